// ----- design/psu_pkg.sv -----
// Shared types and constants for the PNG scanline unfilter block.
`default_nettype none

package psu_pkg;

  typedef enum logic [2:0] {
    FILT_NONE,
    FILT_SUB,
    FILT_UP,
    FILT_AVG,
    FILT_PAETH
  } filter_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_PAL,
    KIND_FILT,
    KIND_ERR,
    KIND_DATA
  } item_kind_t;

  localparam logic [2:0] MODE_GRAY  = 3'd0;
  localparam logic [2:0] MODE_RGB   = 3'd1;
  localparam logic [2:0] MODE_PAL   = 3'd2;
  localparam logic [2:0] MODE_GA    = 3'd3;
  localparam logic [2:0] MODE_RGBA  = 3'd4;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MODE   = 2'd2;

  localparam logic [7:0] FILT_LAST  = 8'd4;

  localparam logic       ACT_DATA   = 1'b0;

  // bytes per pixel group; undefined modes act as rgba
  function automatic logic [2:0] bpp_of(input logic [2:0] mode);
    logic [2:0] n;
    case (mode)
      MODE_GRAY: n = 3'd1;
      MODE_RGB:  n = 3'd3;
      MODE_PAL:  n = 3'd1;
      MODE_GA:   n = 3'd2;
      default:   n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- design/psu_pred.sv -----
// Filter predictor and byte reconstruction (None, Sub, Up, Average, Paeth).
`default_nettype none

module psu_pred (
  input  psu_pkg::filter_t filter,
  input  logic [7:0]       a,
  input  logic [7:0]       b,
  input  logic [7:0]       c,
  input  logic [7:0]       raw,
  output logic [7:0]       cur
);
  import psu_pkg::*;

  logic [8:0]        avg_sum;
  logic signed [9:0] pa_d;
  logic signed [9:0] pb_d;
  logic signed [9:0] pc_d;
  logic [9:0]        pa;
  logic [9:0]        pb;
  logic [9:0]        pc;
  logic [7:0]        pred;

  assign avg_sum = {1'b0, a} + {1'b0, b};

  // p - a = b - c, p - b = a - c, p - c = (b - c) + (a - c)
  assign pa_d = $signed({2'b00, b}) - $signed({2'b00, c});
  assign pb_d = $signed({2'b00, a}) - $signed({2'b00, c});
  assign pc_d = pa_d + pb_d;

  assign pa = pa_d[9] ? 10'(-pa_d) : 10'(pa_d);
  assign pb = pb_d[9] ? 10'(-pb_d) : 10'(pb_d);
  assign pc = pc_d[9] ? 10'(-pc_d) : 10'(pc_d);

  always_comb begin
    case (filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc)        pred = b;
        else                      pred = c;
      end
      default:    pred = 8'd0;
    endcase
  end

  assign cur = raw + pred;

endmodule

`default_nettype wire

// ----- design/png_scanline_unfilter_rgba.sv -----
// PNG scanline unfilter with colour expansion to 32-bit rgba pixels.
// Input channel (in_valid/in_ready): one item per transfer. action 0 carries one
// inflated image byte (the filter type at each line start), action 1 writes
// palette entry palette_index with palette_color.
// Output channel (out_valid/out_ready): one pixel per completed pixel group,
// with line_end/image_end flags; status 1 reports a filter type above 4, after
// which image bytes are dropped until reset (palette writes still land).
// Throughput: one byte per clock unless a result waits on a stalled output. The
// left-byte feedback (predict, add, shift) is combinational in stage 1; the previous
// line sits in a one-port-read, one-port-write RAM of MAX_WIDTH*4 bytes.
// A result passes the stage 1 register, then the output register (line RAM
// read at the transfer, then reconstruct and palette read into the output register).
// Stall: the output register holds a result while out_ready is low; items that
// yield no result keep flowing, and one more item is taken before in_ready drops.
// Reset: registers return to width 1, height 1, rgba; palette reads as unwritten;
// next byte is a filter type on a first line. The line RAM needs no clearing. The
// user writes registers (cfg_write/cfg_index/cfg_data) only while idle; unenforced.
`default_nettype none

module png_scanline_unfilter_rgba #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [23:0] palette_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel,
  output logic        line_end,
  output logic        image_end,
  output logic        status,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import psu_pkg::*;

  localparam int DEPTH = MAX_WIDTH * 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (AW + 1 > 15) ? AW + 1 : 15;
  localparam int WLIM  = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam logic [12:0] WMAX = 13'(WLIM);

  // configuration
  logic [12:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 16'd1;
      color_mode   <= MODE_RGBA;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIDTH:  image_width  <= cfg_data[12:0];
        CFG_HEIGHT: image_height <= cfg_data;
        CFG_MODE:   color_mode   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // front end: line position tracking
  logic          in_line;
  logic [AW-1:0] idx;
  logic [1:0]    idx_mod3;
  logic [15:0]   line_count;
  logic          first_line;
  logic          error_stop;

  logic          in_accept;
  item_kind_t    kind_in;
  logic [2:0]    bpp;
  logic [12:0]   width_eff;
  logic [14:0]   line_bytes;
  logic [15:0]   height_eff;
  logic [15:0]   lc_inc;
  logic          last_in;
  logic          wrap_in;
  logic          done_in;

  logic          s1_valid;
  logic          s1_adv;
  logic          s1_res;

  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign bpp       = bpp_of(color_mode);

  always_comb begin
    if (image_width == 13'd0)     width_eff = 13'd1;
    else if (image_width > WMAX)  width_eff = WMAX;
    else                          width_eff = image_width;

    case (bpp)
      3'd1:    line_bytes = {2'b00, width_eff};
      3'd2:    line_bytes = {1'b0, width_eff, 1'b0};
      3'd3:    line_bytes = {2'b00, width_eff} + {1'b0, width_eff, 1'b0};
      default: line_bytes = {width_eff, 2'b00};
    endcase

    case (bpp)
      3'd1:    done_in = 1'b1;
      3'd2:    done_in = idx[0];
      3'd3:    done_in = (idx_mod3 == 2'd2);
      default: done_in = (idx[1:0] == 2'b11);
    endcase

    height_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    lc_inc     = line_count + 16'd1;
    wrap_in    = lc_inc >= height_eff;
    last_in    = (CW'(idx) + CW'(1)) >= CW'(line_bytes);

    if (action != ACT_DATA)          kind_in = KIND_PAL;
    else if (error_stop)             kind_in = KIND_NOP;
    else if (!in_line)               kind_in = (data_byte > FILT_LAST) ? KIND_ERR : KIND_FILT;
    else                             kind_in = KIND_DATA;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_line    <= 1'b0;
      idx        <= '0;
      idx_mod3   <= 2'd0;
      line_count <= 16'd0;
      first_line <= 1'b1;
      error_stop <= 1'b0;
    end else if (in_accept) begin
      case (kind_in)
        KIND_ERR:  error_stop <= 1'b1;
        KIND_FILT: begin
          in_line  <= 1'b1;
          idx      <= '0;
          idx_mod3 <= 2'd0;
        end
        KIND_DATA: begin
          if (last_in) begin
            in_line    <= 1'b0;
            line_count <= wrap_in ? 16'd0 : lc_inc;
            first_line <= wrap_in;
          end else begin
            idx      <= idx + AW'(1);
            idx_mod3 <= (idx_mod3 == 2'd2) ? 2'd0 : idx_mod3 + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // stage 1: reconstruct
  item_kind_t    s1_kind;
  logic [7:0]    s1_raw;
  logic [AW-1:0] s1_idx;
  logic          s1_done;
  logic          s1_last;
  logic          s1_wrap;
  logic          s1_up_zero;
  logic [7:0]    s1_pal_idx;
  logic [23:0]   s1_pal_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind      <= kind_in;
      s1_raw       <= data_byte;
      s1_idx       <= idx;
      s1_done      <= done_in;
      s1_last      <= last_in;
      s1_wrap      <= wrap_in;
      s1_up_zero   <= first_line;
      s1_pal_idx   <= palette_index;
      s1_pal_color <= palette_color;
    end
  end

  logic [7:0] line_store [DEPTH];
  logic [7:0] ls_q;
  logic [7:0] cur;

  // Reads are issued for the next byte while the previous one writes back;
  // adjacent bytes never share an address, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (in_accept && kind_in == KIND_DATA) begin
      ls_q <= line_store[idx];
    end
    if (s1_adv && s1_kind == KIND_DATA) begin
      line_store[s1_idx] <= cur;
    end
  end

  filter_t     filter_kind;
  logic [31:0] left_bytes;
  logic [31:0] upleft_bytes;
  logic [23:0] pixel_gather;
  logic [1:0]  bsel;
  logic [7:0]  left;
  logic [7:0]  up;
  logic [7:0]  upleft;
  logic [31:0] gathered;

  assign bsel     = 2'(bpp - 3'd1);
  assign left     = left_bytes[{bsel, 3'b000} +: 8];
  assign upleft   = upleft_bytes[{bsel, 3'b000} +: 8];
  assign up       = s1_up_zero ? 8'd0 : ls_q;
  assign gathered = {pixel_gather, cur};

  psu_pred u_pred (
    .filter (filter_kind),
    .a      (left),
    .b      (up),
    .c      (upleft),
    .raw    (s1_raw),
    .cur    (cur)
  );

  logic s2_valid;

  assign s1_res = (s1_kind == KIND_ERR) || (s1_kind == KIND_DATA && s1_done);
  assign s1_adv = s1_valid && (!s1_res || !s2_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_kind  <= FILT_NONE;
      left_bytes   <= 32'd0;
      upleft_bytes <= 32'd0;
      pixel_gather <= 24'd0;
    end else if (s1_adv) begin
      case (s1_kind)
        KIND_FILT: begin
          filter_kind  <= filter_t'(s1_raw[2:0]);
          left_bytes   <= 32'd0;
          upleft_bytes <= 32'd0;
          pixel_gather <= 24'd0;
        end
        KIND_DATA: begin
          left_bytes   <= {left_bytes[23:0], cur};
          upleft_bytes <= {upleft_bytes[23:0], up};
          pixel_gather <= gathered[23:0];
        end
        default: ;
      endcase
    end
  end

  // palette: RAM plus per-entry written flags
  logic [23:0]  pal_mem [256];
  logic [255:0] pal_vld;
  logic [23:0]  pal_q;
  logic         pal_vq;

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_vld <= '0;
    end else if (s1_adv && s1_kind == KIND_PAL) begin
      pal_vld[s1_pal_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_kind == KIND_PAL) begin
      pal_mem[s1_pal_idx] <= s1_pal_color;
    end
    if (s1_adv && s1_kind == KIND_DATA) begin
      pal_q  <= pal_mem[cur];
      pal_vq <= pal_vld[cur];
    end
  end

  // stage 2: output register
  logic [31:0] s2_w;
  logic        s2_line_end;
  logic        s2_image_end;
  logic        s2_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv && s1_res) begin
      s2_valid <= 1'b1;
    end else if (out_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      s2_w         <= gathered;
      s2_status    <= (s1_kind == KIND_ERR);
      s2_line_end  <= (s1_kind == KIND_DATA) && s1_last;
      s2_image_end <= (s1_kind == KIND_DATA) && s1_last && s1_wrap;
    end
  end

  always_comb begin
    if (s2_status) begin
      pixel = 32'd0;
    end else begin
      case (color_mode)
        MODE_GRAY: pixel = {8'hff, s2_w[7:0], s2_w[7:0], s2_w[7:0]};
        MODE_RGB:  pixel = {8'hff, s2_w[7:0], s2_w[15:8], s2_w[23:16]};
        MODE_PAL:  pixel = pal_vq ? {8'hff, pal_q} : 32'd0;
        MODE_GA:   pixel = {s2_w[7:0], s2_w[15:8], s2_w[15:8], s2_w[15:8]};
        default:   pixel = {s2_w[7:0], s2_w[15:8], s2_w[23:16], s2_w[31:24]};
      endcase
    end
  end

  assign out_valid = s2_valid;
  assign line_end  = s2_line_end;
  assign image_end = s2_image_end;
  assign status    = s2_status;

endmodule

`default_nettype wire

// ----- test/tb_png_scanline_unfilter_rgba.sv -----
// Testbench for the PNG scanline unfilter: directed rows, random images, checked pixel stream.
`timescale 1ns / 100ps

module tb_png_scanline_unfilter_rgba;
  import psu_pkg::*;

  localparam int MAX_W = 4096;
  localparam int LINE_BYTES_MAX = MAX_W * 4;
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS = 620;
  // ~1.9k items; even at 64% stall and long sender gaps this stays far below
  localparam int unsigned LIMIT = 1_000_000;

  localparam logic       ACT_PAL     = 1'b1;
  localparam logic [7:0] FILT_BAD    = FILT_LAST + 8'd1;
  localparam logic [2:0] MODE_HIGH   = 3'd7;
  localparam logic [15:0] HEIGHT_OPEN = 16'hffff;

  typedef struct packed {
    logic [31:0] pixel;
    logic        line_end;
    logic        image_end;
    logic        status;
  } pixel_out_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_op_t;

  typedef struct {
    row_op_t     op;
    logic        act;
    logic [7:0]  dbyte;
    logic [7:0]  pidx;
    logic [23:0] pcol;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    bit          typed;
    pixel_out_t  want;
  } plan_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = ACT_DATA;
  logic [7:0]  data_byte = 8'd0;
  logic [7:0]  palette_index = 8'd0;
  logic [23:0] palette_color = 24'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pixel;
  logic        line_end;
  logic        image_end;
  logic        status;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data = 16'd0;

  png_scanline_unfilter_rgba DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .data_byte(data_byte),
    .palette_index(palette_index), .palette_color(palette_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel(pixel), .line_end(line_end), .image_end(image_end), .status(status),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // unfilter state mirror
  logic [7:0]  prev_line [LINE_BYTES_MAX];
  logic [23:0] pal_rgb [256];
  bit          pal_set [256];
  logic [31:0] left_q, upleft_q;
  int unsigned byte_pos;
  logic [15:0] lines_in_image;
  filter_t     filt;
  logic [23:0] gather;
  bit          on_top_line;
  bit          halted;
  logic [12:0] reg_width;
  logic [15:0] reg_height;
  logic [2:0]  reg_mode;

  pixel_out_t  pixels_due [$];
  plan_row_t   plan [$];
  int          n_lead;
  bit          use_typed = 1'b0;
  pixel_out_t  typed_result = '0;
  int unsigned items_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  function automatic void reset_unfilter_state();
    reg_width = 13'd1;
    reg_height = 16'd1;
    reg_mode = MODE_RGBA;
    foreach (pal_set[k]) begin
      pal_set[k] = 1'b0;
      pal_rgb[k] = 24'd0;
    end
    left_q = '0;
    upleft_q = '0;
    byte_pos = 0;
    lines_in_image = '0;
    filt = FILT_NONE;
    gather = '0;
    on_top_line = 1'b1;
    halted = 1'b0;
  endfunction

  function automatic logic [31:0] expand_pixel(input logic [31:0] w);
    case (reg_mode)
      MODE_GRAY: return {8'hff, {3{w[7:0]}}};
      MODE_RGB:  return {8'hff, w[7:0], w[15:8], w[23:16]};
      MODE_PAL:  return pal_set[w[7:0]] ? {8'hff, pal_rgb[w[7:0]]} : 32'h0;
      MODE_GA:   return {w[7:0], {3{w[15:8]}}};
      default:   return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endcase
  endfunction

  // one accepted item; returns 1 when it yields a pixel or error result
  function automatic bit unfilter_byte(input logic act, input logic [7:0] raw,
                                       input logic [7:0] pidx, input logic [23:0] pcol,
                                       output pixel_out_t res);
    int unsigned wid, hgt, bpp, lbytes, idx;
    int lf, up, ul, pred, p, pa, pb, pc;
    logic [7:0] cur;
    logic [31:0] w;
    bit last, done;
    res = '0;
    if (act == ACT_PAL) begin
      pal_rgb[pidx] = pcol;
      pal_set[pidx] = 1'b1;
      return 1'b0;
    end
    if (halted) return 1'b0;
    if (byte_pos == 0) begin
      if (raw > FILT_LAST) begin
        halted = 1'b1;
        res.status = 1'b1;
        return 1'b1;
      end
      filt = filter_t'(raw[2:0]);
      left_q = '0;
      upleft_q = '0;
      gather = '0;
      byte_pos = 1;
      return 1'b0;
    end
    wid = (reg_width == 0) ? 1 : reg_width;
    if (wid > MAX_W) wid = MAX_W;
    hgt = (reg_height == 0) ? 1 : reg_height;
    case (reg_mode) inside
      MODE_GRAY, MODE_PAL: bpp = 1;
      MODE_RGB:            bpp = 3;
      MODE_GA:             bpp = 2;
      default:             bpp = 4;
    endcase
    lbytes = wid * bpp;
    idx = (byte_pos - 1) % LINE_BYTES_MAX;
    up = on_top_line ? 0 : int'(prev_line[idx]);
    lf = int'((left_q >> (8 * (bpp - 1))) & 32'hff);
    ul = int'((upleft_q >> (8 * (bpp - 1))) & 32'hff);
    case (filt)
      FILT_SUB:   pred = lf;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = (lf + up) >> 1;
      FILT_PAETH: begin
        p = lf + up - ul;
        pa = (p > lf) ? p - lf : lf - p;
        pb = (p > up) ? p - up : up - p;
        pc = (p > ul) ? p - ul : ul - p;
        if (pa <= pb && pa <= pc) pred = lf;
        else if (pb <= pc) pred = up;
        else pred = ul;
      end
      default:    pred = 0;
    endcase
    cur = 8'(int'(raw) + pred);
    prev_line[idx] = cur;
    left_q = {left_q[23:0], cur};
    upleft_q = {upleft_q[23:0], 8'(up)};
    w = {gather, cur};
    gather = w[23:0];
    done = (idx % bpp) == bpp - 1;
    last = idx + 1 >= lbytes;
    byte_pos = last ? 0 : byte_pos + 1;
    if (last) begin
      lines_in_image = lines_in_image + 16'd1;
      if (lines_in_image >= hgt) begin
        lines_in_image = '0;
        on_top_line = 1'b1;
        res.image_end = done;
      end else begin
        on_top_line = 1'b0;
      end
      res.line_end = done;
    end
    if (!done) return 1'b0;
    res.pixel = expand_pixel(w);
    return 1'b1;
  endfunction

  // output check first, then prediction of the input transfer of the same edge
  always @(posedge clk) begin
    pixel_out_t got, due, calc;
    bit has;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {pixel, line_end, image_end, status};
        if (pixels_due.size() == 0) begin
          $display("%0t: result with none due: pixel %h line_end %b image_end %b status %b",
                   $time, got.pixel, got.line_end, got.image_end, got.status);
          mismatches++;
        end else begin
          due = pixels_due.pop_front();
          if (got.pixel !== due.pixel) begin
            $display("%0t: pixel expected %h got %h", $time, due.pixel, got.pixel);
            mismatches++;
          end
          if (got.line_end !== due.line_end) begin
            $display("%0t: line_end expected %b got %b", $time, due.line_end, got.line_end);
            mismatches++;
          end
          if (got.image_end !== due.image_end) begin
            $display("%0t: image_end expected %b got %b", $time, due.image_end, got.image_end);
            mismatches++;
          end
          if (got.status !== due.status) begin
            $display("%0t: status expected %b got %b", $time, due.status, got.status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        has = unfilter_byte(action, data_byte, palette_index, palette_color, calc);
        if (use_typed) pixels_due.push_back(typed_result);
        else if (has) pixels_due.push_back(calc);
        items_taken++;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout, %0d results still due", $time, pixels_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic [7:0] pi,
                           input logic [23:0] pc, input bit typed = 1'b0,
                           input pixel_out_t want = '0);
    int unsigned target;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    data_byte <= b;
    palette_index <= pi;
    palette_color <= pc;
    use_typed = typed;
    typed_result = want;
    target = items_taken + 1;
    do @(posedge clk); while (!in_ready);
    // let the monitor take this transfer before the state is read
    wait (items_taken == target);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WIDTH:  reg_width = val[12:0];
      CFG_HEIGHT: reg_height = val;
      CFG_MODE:   reg_mode = val[2:0];
      default:    ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every pixel is out and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_rows(input int lo, input int hi);
    for (int i = lo; i < hi; i++) begin
      if (plan[i].op == ROW_REG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_item(plan[i].act, plan[i].dbyte, plan[i].pidx, plan[i].pcol,
                  plan[i].typed, plan[i].want);
      end
    end
  endtask

  task automatic random_line();
    int unsigned eff;
    send_item(ACT_DATA, 8'($urandom_range(0, 4)), 8'($urandom), 24'($urandom));
    do begin
      if ($urandom_range(0, 9) == 0)
        send_item(ACT_PAL, 8'($urandom), 8'($urandom), 24'($urandom));
      // occasional narrowing mid-line: safe, the line store is only read below the old end
      if ($urandom_range(0, 299) == 0) begin
        eff = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
        settle();
        write_reg(CFG_WIDTH, 16'($urandom_range(1, eff)));
      end
      send_item(ACT_DATA, 8'($urandom), 8'($urandom), 24'($urandom));
    end while (byte_pos != 0);
  endtask

  task automatic random_image(input bit reconfigure);
    if (reconfigure) begin
      settle();
      write_reg(CFG_MODE, 16'($urandom_range(0, 7)));
      write_reg(CFG_WIDTH, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(10, 40))
                                                        : 16'($urandom_range(0, 8)));
      write_reg(CFG_HEIGHT, ($urandom_range(0, 9) == 0) ? HEIGHT_OPEN
                                                         : 16'($urandom_range(0, 4)));
    end
    do begin
      random_line();
      // an open-ended image gets closed by lowering the height between lines
      if (reg_height == HEIGHT_OPEN && lines_in_image != 0 && $urandom_range(0, 2) == 0) begin
        settle();
        write_reg(CFG_HEIGHT, 16'($urandom_range(0, lines_in_image)));
      end
    end while (lines_in_image != 0);
  endtask

  function automatic plan_row_t item_row(input logic act, input logic [7:0] b,
                                         input logic [7:0] pi = 8'd0,
                                         input logic [23:0] pc = 24'd0);
    plan_row_t r;
    r = '{op: ROW_ITEM, act: act, dbyte: b, pidx: pi, pcol: pc, reg_idx: CFG_WIDTH,
          reg_val: 16'd0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [7:0] b, input logic [31:0] px,
                                          input logic le, input logic ie, input logic st);
    plan_row_t r;
    r = item_row(ACT_DATA, b);
    r.typed = 1'b1;
    r.want = {px, le, ie, st};
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t r;
    r = item_row(ACT_DATA, 8'd0);
    r.op = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  initial begin
    int unsigned goal;
    reset_unfilter_state();

    // reset defaults: rgba, one pixel per line and image
    plan.push_back(item_row(ACT_DATA, 8'(FILT_NONE)));
    plan.push_back(item_row(ACT_DATA, 8'h11));
    plan.push_back(item_row(ACT_DATA, 8'h22));
    plan.push_back(item_row(ACT_DATA, 8'h33));
    plan.push_back(typed_row(8'h44, 32'h44332211, 1'b1, 1'b1, 1'b0));
    // palette extremes, then an entry never written
    plan.push_back(item_row(ACT_PAL, 8'h5a, 8'd0, 24'hffffff));
    plan.push_back(item_row(ACT_PAL, 8'ha5, 8'd255, 24'h000000));
    plan.push_back(reg_row(CFG_MODE, 16'(MODE_PAL)));
    plan.push_back(reg_row(CFG_WIDTH, 16'd3));
    plan.push_back(item_row(ACT_DATA, 8'(FILT_NONE)));
    plan.push_back(typed_row(8'd0, 32'hffffffff, 1'b0, 1'b0, 1'b0));
    plan.push_back(typed_row(8'd255, 32'hff000000, 1'b0, 1'b0, 1'b0));
    plan.push_back(typed_row(8'd7, 32'h00000000, 1'b1, 1'b1, 1'b0));
    // zero width and height act as one
    plan.push_back(reg_row(CFG_MODE, 16'(MODE_GRAY)));
    plan.push_back(reg_row(CFG_WIDTH, 16'd0));
    plan.push_back(reg_row(CFG_HEIGHT, 16'd0));
    plan.push_back(item_row(ACT_DATA, 8'(FILT_SUB)));
    plan.push_back(typed_row(8'hff, 32'hffffffff, 1'b1, 1'b1, 1'b0));
    // gray alpha: average on the top line, paeth against it on the next
    plan.push_back(reg_row(CFG_MODE, 16'(MODE_GA)));
    plan.push_back(reg_row(CFG_WIDTH, 16'd1));
    plan.push_back(reg_row(CFG_HEIGHT, 16'd2));
    plan.push_back(item_row(ACT_DATA, 8'(FILT_AVG)));
    plan.push_back(item_row(ACT_DATA, 8'h80));
    plan.push_back(item_row(ACT_DATA, 8'h7f));
    plan.push_back(item_row(ACT_DATA, 8'(FILT_PAETH)));
    plan.push_back(item_row(ACT_DATA, 8'hc3));
    plan.push_back(item_row(ACT_DATA, 8'h3c));
    // undefined mode acts as rgba; width cut mid-line ends it without a pixel
    plan.push_back(reg_row(CFG_MODE, 16'(MODE_HIGH)));
    plan.push_back(reg_row(CFG_WIDTH, 16'd2));
    plan.push_back(reg_row(CFG_HEIGHT, 16'd1));
    plan.push_back(item_row(ACT_DATA, 8'(FILT_UP)));
    plan.push_back(item_row(ACT_DATA, 8'h01));
    plan.push_back(item_row(ACT_DATA, 8'h02));
    plan.push_back(item_row(ACT_DATA, 8'h03));
    plan.push_back(item_row(ACT_DATA, 8'h04));
    plan.push_back(item_row(ACT_DATA, 8'h05));
    plan.push_back(reg_row(CFG_WIDTH, 16'd1));
    plan.push_back(item_row(ACT_DATA, 8'h06));
    n_lead = plan.size();
    // closing rows: bad filter stops image data for good, palette writes still land
    plan.push_back(typed_row(FILT_BAD, 32'h0, 1'b0, 1'b0, 1'b1));
    plan.push_back(item_row(ACT_DATA, 8'h00));
    plan.push_back(item_row(ACT_PAL, 8'h00, 8'h10, 24'h123456));
    plan.push_back(item_row(ACT_DATA, 8'hff));
    plan.push_back(item_row(ACT_DATA, 8'h80, 8'hff, 24'hffffff));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 35;
    stall_pct = 64;
    run_rows(0, n_lead);
    goal = items_taken + PHASE_ITEMS;
    while (items_taken < goal) random_image($urandom_range(0, 2) == 0);

    gap_pct = 64;
    stall_pct = 35;
    goal = items_taken + PHASE_ITEMS;
    while (items_taken < goal) random_image($urandom_range(0, 2) == 0);

    gap_pct = 0;
    stall_pct = 0;
    goal = items_taken + PHASE_ITEMS;
    while (items_taken < goal) random_image($urandom_range(0, 2) == 0);

    settle();
    run_rows(n_lead, plan.size());

    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
